FILE: rtl/lebuf_pkg.sv
// ----------------------------------------------------------------------------
// lebuf_pkg: shared types and constants of the line edit buffer
// Action codes, character limits, the cell operation code and the layout of
// one result transaction.
// ----------------------------------------------------------------------------
package lebuf_pkg;

  // Width of a character code and of a position or length field
  localparam int CHAR_W = 7;
  localparam int POS_W  = 7;

  // Action codes
  localparam logic [2:0] ACT_INSERT    = 3'd0;
  localparam logic [2:0] ACT_LEFT      = 3'd1;
  localparam logic [2:0] ACT_RIGHT     = 3'd2;
  localparam logic [2:0] ACT_BACKSPACE = 3'd3;
  localparam logic [2:0] ACT_DELETE    = 3'd4;
  localparam logic [2:0] ACT_COMMIT    = 3'd5;

  // Printable range: above the last control code, below DEL
  localparam logic [CHAR_W-1:0] CHAR_LAST_CTRL = 7'd31;
  localparam logic [CHAR_W-1:0] CHAR_DEL       = 7'd127;

  // Operation that one storage cell performs in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } lebuf_cell_op_t;

  // One result transaction
  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [POS_W-1:0]  line_length;
    logic              char_valid;
    logic [CHAR_W-1:0] out_char;
    logic              last_result;
    logic              insert_dropped;
  } lebuf_result_t;

endpackage

FILE: rtl/line_edit_buffer.sv
// ----------------------------------------------------------------------------
// line_edit_buffer: single-line edit buffer with a cursor
// Row of character cells with cursor and length control and a two-deep
// result queue.
// ----------------------------------------------------------------------------
// Each edit action (insert, left, right, backspace, delete) is applied to the
// whole row together: every cell of the row shifts or loads at once, whatever
// the cursor position, and its status result is registered into the result
// queue. A commit of a non-empty line occupies the block until the line has
// drained: the row shifts left once per cycle while the skid slot is empty,
// and cell 0 supplies one character per result, the last marked with
// tlast; a commit of an empty line gives one status result at once. Two
// result slots sit between the core and the master side, so an edit is still
// taken while one result waits; input stalls while the second slot is full
// or a commit is draining.
// ----------------------------------------------------------------------------
module line_edit_buffer #(
  parameter int LINE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // slave side, s_tdata fields from bit 0: action[2:0], char_code[9:3]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  // master side, m_tdata fields from bit 0: cursor_pos[6:0], line_length[13:7],
  // out_char[20:14], insert_dropped[21]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic        m_tuser,  // char_valid
  output logic        m_tlast   // last_result
);

  localparam int POS_W  = lebuf_pkg::POS_W;
  localparam int CHAR_W = lebuf_pkg::CHAR_W;
  localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(LINE_DEPTH);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_COMMIT = 1'b1;

  logic                 state, state_next;
  logic [POS_W-1:0]     cursor, cursor_next;
  logic [POS_W-1:0]     length, length_next;
  logic [POS_W-1:0]     remain, remain_next;

  logic                 accept, emit;
  logic [2:0]           act;
  logic [CHAR_W-1:0]    ch;
  logic                 do_ins, do_bs, do_del, do_shift;
  logic                 res_valid;
  lebuf_pkg::lebuf_result_t res;

  logic                 out_valid, skid_valid;
  lebuf_pkg::lebuf_result_t out_q, skid_q;

  logic [CHAR_W-1:0]    cell_q [LINE_DEPTH];

  assign act      = s_tdata[2:0];
  assign ch       = s_tdata[9:3];
  assign s_tready = (state == ST_IDLE) && !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign emit     = (state == ST_COMMIT) && !skid_valid;

  // Decode the action and build the result
  always_comb begin
    state_next  = state;
    cursor_next = cursor;
    length_next = length;
    remain_next = remain;
    do_ins      = 1'b0;
    do_bs       = 1'b0;
    do_del      = 1'b0;
    do_shift    = 1'b0;
    res_valid   = 1'b0;
    res         = '0;
    if (accept) begin
      res_valid       = 1'b1;
      res.last_result = 1'b1;
      unique case (act)
        lebuf_pkg::ACT_INSERT: begin
          if (ch > lebuf_pkg::CHAR_LAST_CTRL && ch != lebuf_pkg::CHAR_DEL) begin
            if (length >= DEPTH_POS) begin
              res.insert_dropped = 1'b1;
            end else begin
              do_ins      = 1'b1;
              cursor_next = cursor + 1'b1;
              length_next = length + 1'b1;
            end
          end
        end
        lebuf_pkg::ACT_LEFT: begin
          if (cursor != '0) cursor_next = cursor - 1'b1;
        end
        lebuf_pkg::ACT_RIGHT: begin
          if (cursor < length) cursor_next = cursor + 1'b1;
        end
        lebuf_pkg::ACT_BACKSPACE: begin
          if (cursor != '0) begin
            do_bs       = 1'b1;
            cursor_next = cursor - 1'b1;
            length_next = length - 1'b1;
          end
        end
        lebuf_pkg::ACT_DELETE: begin
          if (cursor < length) begin
            do_del      = 1'b1;
            length_next = length - 1'b1;
          end
        end
        lebuf_pkg::ACT_COMMIT: begin
          cursor_next = '0;
          length_next = '0;
          if (length != '0) begin
            res_valid   = 1'b0;
            state_next  = ST_COMMIT;
            remain_next = length;
          end
        end
        default: ;
      endcase
      res.cursor_pos  = cursor_next;
      res.line_length = length_next;
    end else if (emit) begin
      // Drain the line through cell 0
      res_valid       = 1'b1;
      res.char_valid  = 1'b1;
      res.out_char    = cell_q[0];
      res.last_result = (remain == POS_W'(1));
      do_shift        = 1'b1;
      remain_next     = remain - 1'b1;
      if (remain == POS_W'(1)) state_next = ST_IDLE;
    end
  end

  // Row of character cells
  for (genvar i = 0; i < LINE_DEPTH; i++) begin : g_cell
    localparam logic [POS_W-1:0] IDX      = POS_W'(i);
    localparam logic [POS_W-1:0] IDX_NEXT = POS_W'(i + 1);
    lebuf_pkg::lebuf_cell_op_t op;
    logic [CHAR_W-1:0]         left_char, right_char;

    // Choose the cell operation from its place against the cursor
    always_comb begin
      op = lebuf_pkg::CELL_HOLD;
      if (do_ins) begin
        if (IDX > cursor)       op = lebuf_pkg::CELL_FROM_LEFT;
        else if (IDX == cursor) op = lebuf_pkg::CELL_LOAD;
      end else if (do_bs) begin
        if (IDX_NEXT >= cursor) op = lebuf_pkg::CELL_FROM_RIGHT;
      end else if (do_del) begin
        if (IDX >= cursor)      op = lebuf_pkg::CELL_FROM_RIGHT;
      end else if (do_shift) begin
        op = lebuf_pkg::CELL_FROM_RIGHT;
      end
    end

    if (i == 0) begin : g_first
      assign left_char = ch;
    end else begin : g_mid
      assign left_char = cell_q[i-1];
    end
    if (i == LINE_DEPTH - 1) begin : g_last
      assign right_char = cell_q[i];
    end else begin : g_inner
      assign right_char = cell_q[i+1];
    end

    lebuf_cell u_cell (
      .clk        (clk),
      .op         (op),
      .load_char  (ch),
      .left_char  (left_char),
      .right_char (right_char),
      .char_q     (cell_q[i])
    );
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cursor <= '0;
      length <= '0;
      remain <= '0;
    end else begin
      state  <= state_next;
      cursor <= cursor_next;
      length <= length_next;
      remain <= remain_next;
    end
  end

  // Queue results: output slot plus skid slot, kept in order
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !m_tready) begin
      if (res_valid) begin
        skid_q     <= res;
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_q      <= skid_q;
      out_valid  <= 1'b1;
      skid_q     <= res;
      skid_valid <= res_valid;
    end else begin
      out_q     <= res;
      out_valid <= res_valid;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_q.insert_dropped, out_q.out_char,
                     out_q.line_length, out_q.cursor_pos};
  assign m_tuser  = out_q.char_valid;
  assign m_tlast  = out_q.last_result;

endmodule

FILE: rtl/lebuf_cell.sv
// ----------------------------------------------------------------------------
// lebuf_cell: one character cell of the line store
// Holds one character and takes a new one from the insert path or from either
// neighbor, as the operation code says.
// ----------------------------------------------------------------------------
module lebuf_cell (
  input  logic                            clk,
  input  lebuf_pkg::lebuf_cell_op_t       op,
  input  logic [lebuf_pkg::CHAR_W-1:0]    load_char,
  input  logic [lebuf_pkg::CHAR_W-1:0]    left_char,
  input  logic [lebuf_pkg::CHAR_W-1:0]    right_char,
  output logic [lebuf_pkg::CHAR_W-1:0]    char_q
);

  logic [lebuf_pkg::CHAR_W-1:0] char_next;

  // Select the next character
  always_comb begin
    unique case (op)
      lebuf_pkg::CELL_LOAD:       char_next = load_char;
      lebuf_pkg::CELL_FROM_LEFT:  char_next = left_char;
      lebuf_pkg::CELL_FROM_RIGHT: char_next = right_char;
      default:                    char_next = char_q;
    endcase
  end

  // Store the character; contents are undefined until written
  always_ff @(posedge clk) begin
    char_q <= char_next;
  end

endmodule

FILE: rtl/lebuf_checker.sv
// ----------------------------------------------------------------------------
// lebuf_checker: port-level checks of the line edit buffer
// Watches the master side for status and character transaction rules.
// ----------------------------------------------------------------------------
module lebuf_checker #(
  parameter int LINE_DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // Status transactions are single and carry no character
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && m_tdata[20:14] == 7'd0)
    else $error("status result malformed");

  // Character transactions report the cleared line
  a_char_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[13:0] == 14'd0 && !m_tdata[21])
    else $error("committed character result malformed");

  // Cursor stays within the line, line within the store
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |->
      m_tdata[6:0] <= m_tdata[13:7] && m_tdata[13:7] <= 7'(LINE_DEPTH))
    else $error("cursor or length out of range");

endmodule

bind line_edit_buffer lebuf_checker #(.LINE_DEPTH(LINE_DEPTH)) u_lebuf_checker (.*);

FILE: tb/line_edit_buffer_tb.sv
// ----------------------------------------------------------------------------
// line_edit_buffer_tb: self-checking bench for the single-line edit buffer
// Drives edit and commit actions on the slave stream and predicts every
// status and character result. Each result on the master stream is checked
// field by field against the oldest prediction. The run covers directed
// corner cases, a full line with dropped inserts, and random edit sessions
// under several idle and stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module line_edit_buffer_tb;

  localparam int LINE_DEPTH = 64;
  localparam int CHAR_W     = lebuf_pkg::CHAR_W;
  localparam int POS_W      = lebuf_pkg::POS_W;
  // Action codes the block treats as no-ops
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;
  // Cycles with no transaction on either side before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  // Cycles to wait after the last result, longer than a full commit
  localparam int TAIL_CYCLES = 80;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // action[2:0], char_code[9:3], zero fill
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // cursor_pos[6:0], line_length[13:7], out_char[20:14],
                          // insert_dropped[21], zero fill
  logic        m_tuser;   // char_valid
  logic        m_tlast;   // last_result

  // Predicted line state
  logic [CHAR_W-1:0] line_chars [LINE_DEPTH];
  logic [POS_W-1:0]  edit_cursor;
  logic [POS_W-1:0]  edit_len;

  lebuf_pkg::lebuf_result_t expected_results [$];
  lebuf_pkg::lebuf_result_t pending_res;

  int send_idle_pct;
  int recv_stall_pct;
  int fail_cnt;
  int n_actions;
  int n_results;
  int n_commits;
  int n_dropped;
  int quiet_cycles;

  line_edit_buffer #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Build one result of the predicted sequence
  function automatic lebuf_pkg::lebuf_result_t make_result(input logic [POS_W-1:0] cp,
                                                           input logic [POS_W-1:0] len,
                                                           input logic valid,
                                                           input logic [CHAR_W-1:0] ch,
                                                           input logic last,
                                                           input logic dropped);
    lebuf_pkg::lebuf_result_t res;
    res.cursor_pos     = cp;
    res.line_length    = len;
    res.char_valid     = valid;
    res.out_char       = ch;
    res.last_result    = last;
    res.insert_dropped = dropped;
    return res;
  endfunction

  // Apply one accepted action to the predicted line and queue its results
  function automatic void predict_line_edit(input logic [2:0] act,
                                            input logic [CHAR_W-1:0] ch);
    int   k;
    int   n;
    logic dropped;
    dropped = 1'b0;
    unique case (act)
      lebuf_pkg::ACT_INSERT: begin
        if (ch > lebuf_pkg::CHAR_LAST_CTRL && ch < lebuf_pkg::CHAR_DEL) begin
          if (int'(edit_len) >= LINE_DEPTH) begin
            dropped = 1'b1;
            n_dropped++;
          end else begin
            for (k = int'(edit_len); k > int'(edit_cursor); k--)
              line_chars[k] = line_chars[k-1];
            line_chars[edit_cursor] = ch;
            edit_cursor++;
            edit_len++;
          end
        end
      end
      lebuf_pkg::ACT_LEFT: begin
        if (edit_cursor > 0) edit_cursor--;
      end
      lebuf_pkg::ACT_RIGHT: begin
        if (edit_cursor < edit_len) edit_cursor++;
      end
      lebuf_pkg::ACT_BACKSPACE: begin
        if (edit_cursor > 0) begin
          for (k = int'(edit_cursor) - 1; k + 1 < int'(edit_len); k++)
            line_chars[k] = line_chars[k+1];
          edit_cursor--;
          edit_len--;
        end
      end
      lebuf_pkg::ACT_DELETE: begin
        if (edit_cursor < edit_len) begin
          for (k = int'(edit_cursor); k + 1 < int'(edit_len); k++)
            line_chars[k] = line_chars[k+1];
          edit_len--;
        end
      end
      lebuf_pkg::ACT_COMMIT: begin
        n = int'(edit_len);
        edit_cursor = '0;
        edit_len    = '0;
        n_commits++;
        if (n == 0) begin
          expected_results.push_back(make_result('0, '0, 1'b0, '0, 1'b1, 1'b0));
        end else begin
          for (k = 0; k < n; k++)
            expected_results.push_back(make_result('0, '0, 1'b1, line_chars[k],
                                                   k == n - 1, 1'b0));
        end
        return;
      end
      default: ;
    endcase
    expected_results.push_back(make_result(edit_cursor, edit_len, 1'b0, '0, 1'b1, dropped));
  endfunction

  // Offer one action, with a random gap first, and hold it until taken
  task automatic send_action(input logic [2:0] act, input logic [CHAR_W-1:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, ch, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_line_edit(act, ch);
    n_actions++;
  endtask

  // Hold the sender off until every predicted result has arrived
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] rand_printable();
    return CHAR_W'($urandom_range(lebuf_pkg::CHAR_DEL - 1, lebuf_pkg::CHAR_LAST_CTRL + 1));
  endfunction

  // Corner cases on an empty and a short line, every action code
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_action(lebuf_pkg::ACT_COMMIT, 7'd0);
    send_action(lebuf_pkg::ACT_LEFT, 7'd0);
    send_action(lebuf_pkg::ACT_BACKSPACE, 7'd0);
    send_action(lebuf_pkg::ACT_RIGHT, 7'd0);
    send_action(lebuf_pkg::ACT_DELETE, 7'd0);
    send_action(lebuf_pkg::ACT_INSERT, lebuf_pkg::CHAR_LAST_CTRL + 7'd1);
    send_action(lebuf_pkg::ACT_INSERT, lebuf_pkg::CHAR_DEL - 7'd1);
    send_action(lebuf_pkg::ACT_INSERT, lebuf_pkg::CHAR_DEL);
    send_action(lebuf_pkg::ACT_INSERT, 7'd0);
    send_action(lebuf_pkg::ACT_INSERT, lebuf_pkg::CHAR_LAST_CTRL);
    send_action(lebuf_pkg::ACT_LEFT, 7'd0);
    send_action(lebuf_pkg::ACT_INSERT, 7'd77);
    send_action(lebuf_pkg::ACT_LEFT, 7'd0);
    send_action(lebuf_pkg::ACT_LEFT, 7'd0);
    send_action(lebuf_pkg::ACT_LEFT, 7'd0);
    send_action(lebuf_pkg::ACT_DELETE, 7'd0);
    send_action(lebuf_pkg::ACT_RIGHT, 7'd0);
    send_action(lebuf_pkg::ACT_RIGHT, 7'd0);
    send_action(lebuf_pkg::ACT_RIGHT, 7'd0);
    send_action(lebuf_pkg::ACT_DELETE, 7'd0);
    send_action(lebuf_pkg::ACT_BACKSPACE, 7'd0);
    send_action(ACT_SPARE_6, lebuf_pkg::CHAR_DEL);
    send_action(ACT_SPARE_7, 7'd0);
    send_action(lebuf_pkg::ACT_COMMIT, 7'd0);
    wait_results_drained();
  endtask

  // Fill the line to capacity, push inserts past it, then commit it all
  task automatic test_full_line();
    int r;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (int'(edit_len) < LINE_DEPTH) begin
      r = $urandom_range(99);
      if (r < 75)      send_action(lebuf_pkg::ACT_INSERT, rand_printable());
      else if (r < 88) send_action(lebuf_pkg::ACT_LEFT, CHAR_W'($urandom));
      else             send_action(lebuf_pkg::ACT_RIGHT, CHAR_W'($urandom));
    end
    repeat (3) send_action(lebuf_pkg::ACT_INSERT, rand_printable());
    send_action(lebuf_pkg::ACT_INSERT, lebuf_pkg::CHAR_DEL);
    send_action(lebuf_pkg::ACT_RIGHT, 7'd0);
    send_action(lebuf_pkg::ACT_BACKSPACE, 7'd0);
    send_action(lebuf_pkg::ACT_INSERT, rand_printable());
    send_action(lebuf_pkg::ACT_INSERT, rand_printable());
    send_action(lebuf_pkg::ACT_COMMIT, 7'd0);
    wait_results_drained();
  endtask

  // Random edit sessions, mostly inserts so lines grow before each commit
  task automatic test_random_edits(input int count, input int idle_pct,
                                   input int stall_pct);
    int                r;
    logic [CHAR_W-1:0] ch;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      r  = $urandom_range(99);
      ch = CHAR_W'($urandom);
      if (r < 55) begin
        send_action(lebuf_pkg::ACT_INSERT, rand_printable());
      end else if (r < 60) begin
        send_action(lebuf_pkg::ACT_INSERT, ($urandom_range(1) != 0) ? lebuf_pkg::CHAR_DEL :
                    CHAR_W'($urandom_range(lebuf_pkg::CHAR_LAST_CTRL)));
      end else if (r < 70) begin
        send_action(lebuf_pkg::ACT_LEFT, ch);
      end else if (r < 80) begin
        send_action(lebuf_pkg::ACT_RIGHT, ch);
      end else if (r < 87) begin
        send_action(lebuf_pkg::ACT_BACKSPACE, ch);
      end else if (r < 94) begin
        send_action(lebuf_pkg::ACT_DELETE, ch);
      end else if (r < 98) begin
        send_action(lebuf_pkg::ACT_COMMIT, ch);
      end else begin
        send_action(($urandom_range(1) != 0) ? ACT_SPARE_6 : ACT_SPARE_7, ch);
      end
    end
    wait_results_drained();
  endtask

  task automatic check_field(input string name, input logic [6:0] exp_val,
                             input logic [6:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_cnt++;
    end
  endtask

  // Stall the master side at random and check each result transaction
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: tdata %h", m_tdata);
        fail_cnt++;
      end else begin
        pending_res = expected_results.pop_front();
        check_field("cursor_pos", pending_res.cursor_pos, m_tdata[6:0]);
        check_field("line_length", pending_res.line_length, m_tdata[13:7]);
        check_field("out_char", pending_res.out_char, m_tdata[20:14]);
        check_field("insert_dropped", 7'(pending_res.insert_dropped), 7'(m_tdata[21]));
        check_field("char_valid", 7'(pending_res.char_valid), 7'(m_tuser));
        check_field("last_result", 7'(pending_res.last_result), 7'(m_tlast));
      end
    end
  end

  // Abandon the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[line_edit_buffer] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fail_cnt       = 0;
    n_actions      = 0;
    n_results      = 0;
    n_commits      = 0;
    n_dropped      = 0;
    quiet_cycles   = 0;
    edit_cursor    = '0;
    edit_len       = '0;
    foreach (line_chars[i]) line_chars[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_line();
    test_random_edits(73, 0, 0);
    test_random_edits(73, 70, 0);
    test_random_edits(73, 0, 70);
    test_random_edits(73, 32, 32);

    // Let any stray result surface before the final verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fail_cnt++;
    end
    $display("covered %0d actions and %0d results: %0d commits, %0d full-line drops",
             n_actions, n_results, n_commits, n_dropped);
    $display("idle patterns: none, sender 70%%, receiver 70%%, both 32%%");
    if (fail_cnt == 0) begin
      $display("[line_edit_buffer] OK");
    end else begin
      $display("[line_edit_buffer] ERROR");
    end
    $finish;
  end

endmodule
